@@ src/apa_pkg.sv @@
// Shared types and constants of the polygon area and perimeter block.
package apa_pkg;

    localparam int COORD_W          = 16;
    localparam int AREA_W           = 43;
    localparam int PERIM_W          = 35;
    localparam int MIN_VERTICES     = 3;
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int PROD_W           = 2 * (COORD_W + 1);
    localparam int RAD_W            = PROD_W + 16;
    localparam int ROOT_W           = RAD_W / 2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic                      edge_en;
        logic                      close_en;
        logic                      last;
        status_t                   status;
    } edge_cmd_t;

endpackage

@@ src/apa_ifs.sv @@
// Vertex and result channel interfaces of the polygon area and perimeter block.
interface vertex_if;
    logic                               valid;
    logic                               ready;
    logic signed [apa_pkg::COORD_W-1:0] x_coord;
    logic signed [apa_pkg::COORD_W-1:0] y_coord;
    logic                               last_vertex;

    modport source (output valid, output x_coord, output y_coord, output last_vertex,
                    input ready);
    modport sink (input valid, input x_coord, input y_coord, input last_vertex,
                  output ready);
endinterface

interface result_if;
    logic                        valid;
    logic                        ready;
    logic [apa_pkg::AREA_W-1:0]  twice_area;
    logic [apa_pkg::PERIM_W-1:0] perimeter_q8;
    logic                        repeated_vertex;
    logic [1:0]                  status;

    modport source (output valid, output twice_area, output perimeter_q8,
                    output repeated_vertex, output status, input ready);
    modport sink (input valid, input twice_area, input perimeter_q8,
                  input repeated_vertex, input status, output ready);
endinterface

@@ src/polygon_area_perimeter.sv @@
// Top level of the polygon area and perimeter block.
// Usage: send the vertices of one closed polygon in order on the vertex channel,
// one transfer each, with last_vertex set on the final one. Each polygon yields one
// transfer on the result channel: twice the absolute area, the perimeter with 8
// fraction bits, the repeated-vertex flag and a status (too few or too many vertices
// give zero area, perimeter and flag).
// Timing: the front end takes a vertex and queues its edge command in the same cycle.
// The back end works each edge in 4 steps of one shared 17x17 multiplier, 25 steps
// of the bit-serial square root and 1 accumulate step. It takes a new edge command
// only when idle; the last vertex also runs the closing edge and then loads the
// result register, and the square root loop sets the sustained vertex rate.
// Reset: empty queue, no result pending, all sums and counts cleared.
// Stall: a pending result holds until taken; the two-entry queue keeps taking
// vertices, then vertex.ready drops until the back end frees a slot.
module polygon_area_perimeter #(
    parameter int MAX_VERTICES = apa_pkg::MAX_VERTICES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    vertex_if.sink   vertex,
    result_if.source result
);
    import apa_pkg::*;

    logic      push_valid, push_ready, pop_valid, pop_ready;
    edge_cmd_t push_data, pop_data;

    apa_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    apa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    apa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

@@ src/apa_front.sv @@
// Front end: accepts vertices, tracks first and previous vertex and count, issues edge commands.
module apa_front #(
    parameter int MAX_VERTICES = apa_pkg::MAX_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    vertex_if.sink             vertex,
    output logic               push_valid,
    input  logic               push_ready,
    output apa_pkg::edge_cmd_t push_data
);
    import apa_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 2);

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             n;
    logic                      in_range;
    logic                      is_first;
    logic                      accept;

    assign vertex.ready = push_ready;
    assign push_valid   = vertex.valid;
    assign accept       = vertex.valid && push_ready;

    always_comb
    begin
        if (count_reg == CW'(MAX_VERTICES + 1))
            n = count_reg;
        else
            n = count_reg + 1'b1;
        in_range = (n <= CW'(MAX_VERTICES));
        is_first = (n == CW'(1));

        push_data.ax       = prev_x_reg;
        push_data.ay       = prev_y_reg;
        push_data.bx       = vertex.x_coord;
        push_data.by       = vertex.y_coord;
        push_data.fx       = is_first ? vertex.x_coord : first_x_reg;
        push_data.fy       = is_first ? vertex.y_coord : first_y_reg;
        push_data.edge_en  = in_range && !is_first;
        push_data.close_en = in_range && vertex.last_vertex;
        push_data.last     = vertex.last_vertex;
        if (n < CW'(MIN_VERTICES))
            push_data.status = ST_FEW;
        else if (!in_range)
            push_data.status = ST_MANY;
        else
            push_data.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (vertex.last_vertex)
            begin
                first_x_reg <= '0;
                first_y_reg <= '0;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
                count_reg   <= '0;
            end
            else
            begin
                if (is_first)
                begin
                    first_x_reg <= vertex.x_coord;
                    first_y_reg <= vertex.y_coord;
                end
                if (in_range)
                begin
                    prev_x_reg <= vertex.x_coord;
                    prev_y_reg <= vertex.y_coord;
                end
                count_reg <= n;
            end
        end
    end

endmodule

@@ src/apa_queue.sv @@
// Short command queue between front end and back end.
module apa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  apa_pkg::edge_cmd_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output apa_pkg::edge_cmd_t pop_data
);
    import apa_pkg::*;

    edge_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

@@ src/apa_back.sv @@
// Back end: per-edge cross term, squared length, bit-serial root, accumulation and result register.
module apa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  apa_pkg::edge_cmd_t pop_data,
    result_if.source           result
);
    import apa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SQRT = 5'b00100,
        S_ACC  = 5'b01000,
        S_OUT  = 5'b10000
    } back_state_t;

    localparam int CNT_W = $clog2(ROOT_W);

    back_state_t               state_reg;
    edge_cmd_t                 cmd_reg;
    logic                      close_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [1:0]                step_reg;
    logic signed [PROD_W-1:0]  term_reg;
    logic [PROD_W-1:0]         d2_reg;
    logic [RAD_W-1:0]          rem_reg, root_reg, bit_reg;
    logic [CNT_W-1:0]          iter_reg;
    logic [AREA_W-1:0]         cross_sum_reg;
    logic [PERIM_W-1:0]        length_sum_reg;
    logic                      dup_reg;

    logic                      out_valid_reg;
    logic [AREA_W-1:0]         area_out_reg;
    logic [PERIM_W-1:0]        perim_out_reg;
    logic                      dup_out_reg;
    status_t                   status_out_reg;

    logic signed [COORD_W:0]   mul_a, mul_b, dx, dy;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         d2_sum;
    logic [RAD_W-1:0]          trial;
    logic [PERIM_W:0]          len_sum_wide;
    logic [AREA_W-1:0]         area_abs;

    assign pop_ready              = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.twice_area      = area_out_reg;
    assign result.perimeter_q8    = perim_out_reg;
    assign result.repeated_vertex = dup_out_reg;
    assign result.status          = status_out_reg;

    always_comb
    begin
        dx = {ax_reg[COORD_W-1], ax_reg} - {bx_reg[COORD_W-1], bx_reg};
        dy = {ay_reg[COORD_W-1], ay_reg} - {by_reg[COORD_W-1], by_reg};
        case (step_reg)
            2'd0:    begin mul_a = {bx_reg[COORD_W-1], bx_reg}; mul_b = {ay_reg[COORD_W-1], ay_reg}; end
            2'd1:    begin mul_a = {ax_reg[COORD_W-1], ax_reg}; mul_b = {by_reg[COORD_W-1], by_reg}; end
            2'd2:    begin mul_a = dx; mul_b = dx; end
            default: begin mul_a = dy; mul_b = dy; end
        endcase
        prod         = mul_a * mul_b;
        d2_sum       = d2_reg + $unsigned(prod);
        trial        = root_reg + bit_reg;
        len_sum_wide = {1'b0, length_sum_reg} + (PERIM_W + 1)'(root_reg[ROOT_W-1:0]);
        area_abs     = cross_sum_reg[AREA_W-1] ? (~cross_sum_reg + 1'b1) : cross_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            close_reg      <= 1'b0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            bx_reg         <= '0;
            by_reg         <= '0;
            step_reg       <= '0;
            term_reg       <= '0;
            d2_reg         <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            bit_reg        <= '0;
            iter_reg       <= '0;
            cross_sum_reg  <= '0;
            length_sum_reg <= '0;
            dup_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            area_out_reg   <= '0;
            perim_out_reg  <= '0;
            dup_out_reg    <= 1'b0;
            status_out_reg <= ST_OK;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        cmd_reg  <= pop_data;
                        step_reg <= '0;
                        if (pop_data.edge_en)
                        begin
                            ax_reg    <= pop_data.ax;
                            ay_reg    <= pop_data.ay;
                            bx_reg    <= pop_data.bx;
                            by_reg    <= pop_data.by;
                            close_reg <= 1'b0;
                            state_reg <= S_MUL;
                        end
                        else if (pop_data.close_en)
                        begin
                            ax_reg    <= pop_data.bx;
                            ay_reg    <= pop_data.by;
                            bx_reg    <= pop_data.fx;
                            by_reg    <= pop_data.fy;
                            close_reg <= 1'b1;
                            state_reg <= S_MUL;
                        end
                        else if (pop_data.last)
                            state_reg <= S_OUT;
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + 1'b1;
                    case (step_reg)
                        2'd0:    term_reg <= prod;
                        2'd1:    term_reg <= term_reg - prod;
                        2'd2:    d2_reg   <= $unsigned(prod);
                        default:
                        begin
                            rem_reg   <= {d2_sum, 16'b0};
                            root_reg  <= '0;
                            bit_reg   <= RAD_W'(1) << (RAD_W - 2);
                            iter_reg  <= '0;
                            state_reg <= S_SQRT;
                        end
                    endcase
                end
                S_SQRT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == CNT_W'(ROOT_W - 1))
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    cross_sum_reg <= cross_sum_reg + AREA_W'(term_reg);
                    if (len_sum_wide[PERIM_W])
                        length_sum_reg <= '1;
                    else
                        length_sum_reg <= len_sum_wide[PERIM_W-1:0];
                    if (ax_reg == bx_reg && ay_reg == by_reg)
                        dup_reg <= 1'b1;
                    step_reg <= '0;
                    if (!close_reg && cmd_reg.close_en)
                    begin
                        ax_reg    <= cmd_reg.bx;
                        ay_reg    <= cmd_reg.by;
                        bx_reg    <= cmd_reg.fx;
                        by_reg    <= cmd_reg.fy;
                        close_reg <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else if (cmd_reg.last)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        status_out_reg <= cmd_reg.status;
                        if (cmd_reg.status == ST_OK)
                        begin
                            area_out_reg  <= area_abs;
                            perim_out_reg <= length_sum_reg;
                            dup_out_reg   <= dup_reg;
                        end
                        else
                        begin
                            area_out_reg  <= '0;
                            perim_out_reg <= '0;
                            dup_out_reg   <= 1'b0;
                        end
                        cross_sum_reg  <= '0;
                        length_sum_reg <= '0;
                        dup_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
